@@ sv/rpld_pkg.sv @@
`default_nettype none

package rpld_pkg;

  // Sizing
  localparam int MAX_PIXEL_BYTES = 3;
  localparam int COORD_BITS      = 16;
  localparam int PIX_W           = 8 * MAX_PIXEL_BYTES;
  localparam int STREAM_W        = 8;
  localparam int BPP_W           = 2;
  localparam int COPY_W          = 9;
  localparam int RUN_W           = 8;
  localparam int KIND_W          = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_RUN     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BPP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]     out_kind;
    logic [COORD_BITS-1:0] run_start;
    logic [COORD_BITS-1:0] run_length;
    logic [PIX_W-1:0]      pixel_value;
    logic [COORD_BITS-1:0] line_first;
    logic [COPY_W-1:0]     line_copies;
    logic                  page_complete;
    logic                  last;
  } result_t;

endpackage

`default_nettype wire

@@ sv/rpld_in_if.sv @@
`default_nettype none

interface rpld_in_if;
  logic                          valid;
  logic                          ready;
  logic [rpld_pkg::STREAM_W-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

@@ sv/rpld_out_if.sv @@
`default_nettype none

interface rpld_out_if;
  logic                            valid;
  logic                            ready;
  logic [rpld_pkg::KIND_W-1:0]     out_kind;
  logic [rpld_pkg::COORD_BITS-1:0] run_start;
  logic [rpld_pkg::COORD_BITS-1:0] run_length;
  logic [rpld_pkg::PIX_W-1:0]      pixel_value;
  logic [rpld_pkg::COORD_BITS-1:0] line_first;
  logic [rpld_pkg::COPY_W-1:0]     line_copies;
  logic                            page_complete;
  logic                            last;

  modport source (
    output valid, output out_kind, output run_start, output run_length,
    output pixel_value, output line_first, output line_copies,
    output page_complete, output last, input ready
  );
  modport sink (
    input valid, input out_kind, input run_start, input run_length,
    input pixel_value, input line_first, input line_copies,
    input page_complete, input last, output ready
  );
endinterface

`default_nettype wire

@@ sv/rpld_cfg_if.sv @@
`default_nettype none

interface rpld_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rpld_pkg::CFG_IDX_W-1:0]  index;
  logic [rpld_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/raster_packbits_line_decoder.sv @@
// PackBits raster line decoder. Takes one compressed byte per cycle on in_i and
// reports pixel runs, one line-done word per finished line (first line index and
// copy count, clamped to the page) and one flag word per byte arriving after the
// page is complete. A byte is decoded in the cycle it is accepted and its one or
// two result words go into a three-word result queue that drains one word per
// cycle on out_o while out_o.ready is high. A byte that finishes a line makes
// two words, so the sustained rate is one byte per cycle except that each
// finished line adds an extra output word; in_i.ready drops while the queue
// holds two or more words. The configuration port is always ready; any write to
// a known register returns the decoder to the start of a page.
`default_nettype none

module raster_packbits_line_decoder (
  input  wire  clk_i,
  input  wire  rst_ni,
  rpld_in_if.sink    in_i,
  rpld_out_if.source out_o,
  rpld_cfg_if.sink   cfg_i
);
  import rpld_pkg::*;

  localparam int QDEPTH = 3;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_REPEAT,
    PH_CODE,
    PH_RUNPIX,
    PH_LITPIX
  } phase_e;

  // Configuration registers
  logic [BPP_W-1:0]      bpp_q, bpp_d;
  logic [COORD_BITS-1:0] width_q, width_d;
  logic [COORD_BITS-1:0] height_q, height_d;

  // Decoder state
  phase_e                phase_q, phase_d;
  logic [COPY_W-1:0]     rc_q, rc_d;
  logic [RUN_W-1:0]      pr_q, pr_d;
  logic [BPP_W-1:0]      bi_q, bi_d;
  logic [PIX_W-1:0]      acc_q, acc_d;
  logic [COORD_BITS-1:0] pos_q, pos_d;
  logic [COORD_BITS-1:0] cur_q, cur_d;
  logic                  page_q, page_d;

  // Result queue
  result_t               slot_q [QDEPTH];
  result_t               slot_d [QDEPTH];
  logic [QCNT_W-1:0]     cnt_q, cnt_d;

  logic                  in_acc, out_pop, cfg_acc;
  logic [BPP_W-1:0]      bpp_eff;
  logic [COORD_BITS-1:0] w_eff, h_eff, rest, left, run_len;
  logic [PIX_W-1:0]      white, acc_new, run_val;
  logic [BPP_W-1:0]      bi_inc;
  logic [COPY_W-1:0]     copies;
  logic                  do_run, line_done, push0, push1;
  result_t               r0, r1;
  logic [QCNT_W-1:0]     base;
  logic [STREAM_W-1:0]   b;

  assign b       = in_i.stream_byte;
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_pop = out_o.valid && out_o.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;

  assign in_i.ready  = (cnt_q <= QCNT_W'(1));
  assign cfg_i.ready = 1'b1;

  // Effective register values: zero acts as one, pixel size clamped
  always_comb begin
    if (bpp_q == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bpp_q > BPP_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp_q;
    end
    w_eff = (width_q == '0) ? COORD_BITS'(1) : width_q;
    h_eff = (height_q == '0) ? COORD_BITS'(1) : height_q;
    for (int j = 0; j < MAX_PIXEL_BYTES; j++) begin
      white[8*j +: 8] = (BPP_W'(j) < bpp_eff) ? 8'hFF : 8'h00;
    end
  end

  // Decode one byte
  always_comb begin
    phase_d  = phase_q;
    rc_d     = rc_q;
    pr_d     = pr_q;
    bi_d     = bi_q;
    acc_d    = acc_q;
    pos_d    = pos_q;
    cur_d    = cur_q;
    page_d   = page_q;
    r0       = '0;
    r1       = '0;
    push0    = 1'b0;
    push1    = 1'b0;
    do_run   = 1'b0;
    run_len  = '0;
    run_val  = '0;
    rest     = w_eff - pos_q;
    left     = h_eff - cur_q;
    acc_new  = {acc_q[PIX_W-9:0], b};
    bi_inc   = bi_q + BPP_W'(1);
    copies   = (COORD_BITS'(rc_q) > left) ? COPY_W'(left) : rc_q;

    if (page_q) begin
      push0            = 1'b1;
      r0.out_kind      = KIND_IGNORED;
      r0.page_complete = 1'b1;
      r0.last          = 1'b1;
    end else begin
      unique case (phase_q)
        PH_REPEAT: begin
          rc_d    = COPY_W'(b) + COPY_W'(1);
          pos_d   = '0;
          phase_d = PH_CODE;
        end
        PH_CODE: begin
          if (b == 8'h80) begin
            do_run  = 1'b1;
            run_len = rest;
            run_val = white;
          end else begin
            bi_d  = '0;
            acc_d = '0;
            if (!b[7]) begin
              pr_d    = b + RUN_W'(1);
              phase_d = PH_RUNPIX;
            end else begin
              pr_d    = ~b + RUN_W'(2);
              phase_d = PH_LITPIX;
            end
          end
        end
        default: begin
          acc_d = acc_new;
          bi_d  = bi_inc;
          if (bi_inc >= bpp_eff) begin
            bi_d    = '0;
            acc_d   = '0;
            do_run  = 1'b1;
            run_val = acc_new;
            if (phase_q == PH_RUNPIX) begin
              run_len = (COORD_BITS'(pr_q) > rest) ? rest : COORD_BITS'(pr_q);
              pr_d    = '0;
              phase_d = PH_CODE;
            end else begin
              run_len = COORD_BITS'(1);
              pr_d    = pr_q - RUN_W'(1);
              if (pr_q == RUN_W'(1)) begin
                phase_d = PH_CODE;
              end
            end
          end
        end
      endcase
    end

    // Emit the run, then the line-done word if the line is full
    line_done = do_run && (run_len == rest);
    if (do_run) begin
      push0          = 1'b1;
      r0.out_kind    = KIND_RUN;
      r0.run_start   = pos_q;
      r0.run_length  = run_len;
      r0.pixel_value = run_val;
      r0.last        = !line_done;
      pos_d          = pos_q + run_len;
    end
    if (line_done) begin
      push1            = 1'b1;
      r1.out_kind      = KIND_LINE;
      r1.line_first    = cur_q;
      r1.line_copies   = copies;
      r1.page_complete = (COORD_BITS'(copies) == left);
      r1.last          = 1'b1;
      cur_d            = cur_q + COORD_BITS'(copies);
      page_d           = (COORD_BITS'(copies) == left);
      phase_d          = PH_REPEAT;
    end
  end

  // Result queue: shift on pop, append new words behind the survivors
  always_comb begin
    base  = cnt_q - QCNT_W'(out_pop);
    cnt_d = base;
    if (in_acc && push0) cnt_d = cnt_d + QCNT_W'(1);
    if (in_acc && push1) cnt_d = cnt_d + QCNT_W'(1);
    for (int i = 0; i < QDEPTH; i++) begin
      slot_d[i] = (out_pop && i < QDEPTH - 1) ? slot_q[(i + 1) % QDEPTH] : slot_q[i];
      if (in_acc && push0 && base == QCNT_W'(i)) slot_d[i] = r0;
      if (in_acc && push1 && base + QCNT_W'(1) == QCNT_W'(i)) slot_d[i] = r1;
    end
  end

  // Configuration writes
  always_comb begin
    bpp_d    = bpp_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_acc) begin
      unique case (cfg_i.index)
        REG_BPP:    bpp_d    = cfg_i.data[BPP_W-1:0];
        REG_WIDTH:  width_d  = cfg_i.data[COORD_BITS-1:0];
        REG_HEIGHT: height_d = cfg_i.data[COORD_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // State, registers and result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= BPP_W'(1);
      width_q  <= COORD_BITS'(1);
      height_q <= COORD_BITS'(1);
      phase_q  <= PH_REPEAT;
      rc_q     <= '0;
      pr_q     <= '0;
      bi_q     <= '0;
      acc_q    <= '0;
      pos_q    <= '0;
      cur_q    <= '0;
      page_q   <= 1'b0;
      cnt_q    <= '0;
      for (int i = 0; i < QDEPTH; i++) slot_q[i] <= '0;
    end else begin
      bpp_q    <= bpp_d;
      width_q  <= width_d;
      height_q <= height_d;
      cnt_q    <= cnt_d;
      for (int i = 0; i < QDEPTH; i++) slot_q[i] <= slot_d[i];
      if (cfg_acc && (cfg_i.index == REG_BPP || cfg_i.index == REG_WIDTH ||
                      cfg_i.index == REG_HEIGHT)) begin
        phase_q <= PH_REPEAT;
        rc_q    <= '0;
        pr_q    <= '0;
        bi_q    <= '0;
        acc_q   <= '0;
        pos_q   <= '0;
        cur_q   <= '0;
        page_q  <= 1'b0;
      end else if (in_acc) begin
        phase_q <= phase_d;
        rc_q    <= rc_d;
        pr_q    <= pr_d;
        bi_q    <= bi_d;
        acc_q   <= acc_d;
        pos_q   <= pos_d;
        cur_q   <= cur_d;
        page_q  <= page_d;
      end
    end
  end

  // Drive the output channel from the queue head
  assign out_o.valid         = (cnt_q != '0);
  assign out_o.out_kind      = slot_q[0].out_kind;
  assign out_o.run_start     = slot_q[0].run_start;
  assign out_o.run_length    = slot_q[0].run_length;
  assign out_o.pixel_value   = slot_q[0].pixel_value;
  assign out_o.line_first    = slot_q[0].line_first;
  assign out_o.line_copies   = slot_q[0].line_copies;
  assign out_o.page_complete = slot_q[0].page_complete;
  assign out_o.last          = slot_q[0].last;

endmodule

`default_nettype wire

@@ sv/rpld_checker.sv @@
`default_nettype none

module rpld_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             out_valid,
  input wire                             out_ready,
  input wire [rpld_pkg::KIND_W-1:0]      out_kind,
  input wire [rpld_pkg::COORD_BITS-1:0]  run_start,
  input wire [rpld_pkg::COORD_BITS-1:0]  run_length,
  input wire [rpld_pkg::COPY_W-1:0]      line_copies,
  input wire                             out_last,
  input wire                             cfg_valid,
  input wire                             cfg_ready
);
  import rpld_pkg::*;

  logic out_acc, cfg_acc;

  assign out_acc = out_valid && out_ready;
  assign cfg_acc = cfg_valid && cfg_ready;

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(run_start) && $stable(run_length) && $stable(line_copies))
    else $error("result word changed while stalled");

  // A run that is not the last word of its byte is followed at once by line-done
  a_line_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_kind == KIND_RUN && !out_last |=> out_valid && out_kind == KIND_LINE)
    else $error("line-done word missing after line-filling run");

  // A finished line is written at least once
  a_copies_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == KIND_LINE |-> line_copies != '0 && out_last)
    else $error("line-done word with zero copies or not last");

  // After the page ends, only flag words come until a register write
  a_page_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_kind == KIND_IGNORED && !cfg_acc |=>
      !(out_valid && out_kind != KIND_IGNORED))
    else $error("decoded word after page end");

endmodule

bind raster_packbits_line_decoder rpld_checker u_rpld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_kind    (out_o.out_kind),
  .run_start   (out_o.run_start),
  .run_length  (out_o.run_length),
  .line_copies (out_o.line_copies),
  .out_last    (out_o.last),
  .cfg_valid   (cfg_i.valid),
  .cfg_ready   (cfg_i.ready)
);

`default_nettype wire

@@ sim/rpld_tb_pkg.sv @@
`timescale 1ns / 1ps

package rpld_tb_pkg;
  import rpld_pkg::*;

  typedef enum logic [1:0] {
    DEC_REPEAT,
    DEC_CODE,
    DEC_RUN_PIXEL,
    DEC_LIT_PIXEL
  } dec_phase_e;

  // PackBits code bytes
  localparam logic [7:0] CODE_WHITE   = 8'h80;
  localparam logic [7:0] CODE_RUN_MAX = 8'h7F;
  localparam logic [7:0] CODE_LIT_MAX = 8'h81;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  class line_decode_scoreboard;
    logic [BPP_W-1:0]      bpp_reg;
    logic [COORD_BITS-1:0] width_reg;
    logic [COORD_BITS-1:0] height_reg;

    dec_phase_e            phase;
    logic [COPY_W-1:0]     line_repeats;
    logic [RUN_W-1:0]      pixels_left;
    logic [1:0]            byte_idx;
    logic [31:0]           pixel_acc;
    logic [COORD_BITS-1:0] position;
    int unsigned           line_index;
    bit                    page_done;

    result_t               expected_words[$];
    int unsigned           failures;

    function new();
      failures = 0;
      bpp_reg = 1;
      width_reg = 1;
      height_reg = 1;
      clear_decoder();
    endfunction

    function void clear_decoder();
      phase = DEC_REPEAT;
      line_repeats = '0;
      pixels_left = '0;
      byte_idx = '0;
      pixel_acc = '0;
      position = '0;
      line_index = 0;
      page_done = 0;
    endfunction

    // Zero acts as one; pixel size saturates at the widest pixel
    function int unsigned eff_bpp();
      int unsigned b;
      b = bpp_reg;
      if (b == 0) b = 1;
      if (b > MAX_PIXEL_BYTES) b = MAX_PIXEL_BYTES;
      return b;
    endfunction

    function int unsigned eff_width();
      return (width_reg == 0) ? 1 : width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // Any known register write re-arms the decoder
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BPP:    bpp_reg = data[BPP_W-1:0];
        REG_WIDTH:  width_reg = data;
        REG_HEIGHT: height_reg = data;
        default:    return;
      endcase
      clear_decoder();
    endfunction

    // Queue a run word, plus a line-done word when the run fills the line
    function void push_run(int unsigned len, logic [PIX_W-1:0] val);
      result_t     r;
      int unsigned left;
      int unsigned copies;
      r = '0;
      r.out_kind = KIND_RUN;
      r.run_start = position;
      r.run_length = COORD_BITS'(len);
      r.pixel_value = val;
      position = position + COORD_BITS'(len);
      if (position < eff_width()) begin
        r.last = 1'b1;
        expected_words.push_back(r);
        return;
      end
      expected_words.push_back(r);
      left = (line_index < eff_height()) ? eff_height() - line_index : 0;
      copies = line_repeats;
      if (copies > left) copies = left;
      r = '0;
      r.out_kind = KIND_LINE;
      r.line_first = COORD_BITS'(line_index);
      r.line_copies = COPY_W'(copies);
      line_index += copies;
      if (line_index >= eff_height()) page_done = 1;
      r.page_complete = page_done;
      r.last = 1'b1;
      expected_words.push_back(r);
      phase = DEC_REPEAT;
    endfunction

    // Advance the decoder by one accepted stream byte
    function void decode_byte(logic [7:0] b);
      int unsigned      w;
      int unsigned      bpp;
      int unsigned      rest;
      int unsigned      len;
      logic [PIX_W-1:0] val;
      result_t          r;
      w = eff_width();
      bpp = eff_bpp();
      rest = (w > position) ? w - position : 0;
      if (page_done) begin
        r = '0;
        r.out_kind = KIND_IGNORED;
        r.page_complete = 1'b1;
        r.last = 1'b1;
        expected_words.push_back(r);
        return;
      end
      case (phase)
        DEC_REPEAT: begin
          line_repeats = {1'b0, b} + 9'd1;
          position = '0;
          phase = DEC_CODE;
        end
        DEC_CODE: begin
          if (b == CODE_WHITE) begin
            push_run(rest, PIX_W'((32'd1 << (8 * bpp)) - 1));
          end else begin
            byte_idx = '0;
            pixel_acc = '0;
            if (b <= CODE_RUN_MAX) begin
              pixels_left = RUN_W'(int'(b) + 1);
              phase = DEC_RUN_PIXEL;
            end else begin
              pixels_left = RUN_W'(257 - int'(b));
              phase = DEC_LIT_PIXEL;
            end
          end
        end
        default: begin
          pixel_acc = {pixel_acc[23:0], b};
          byte_idx = byte_idx + 2'd1;
          if (byte_idx < bpp) return;
          byte_idx = '0;
          val = pixel_acc[PIX_W-1:0];
          pixel_acc = '0;
          if (phase == DEC_RUN_PIXEL) begin
            len = pixels_left;
            if (len > rest) len = rest;
            pixels_left = '0;
            phase = DEC_CODE;
            push_run(len, val);
          end else begin
            pixels_left = pixels_left - 1'b1;
            if (pixels_left == 0) phase = DEC_CODE;
            push_run(1, val);
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    // Match one result word against the oldest expectation
    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        $error("result word with none expected: kind %0h", got.out_kind);
        failures++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("out_kind", want.out_kind, got.out_kind);
      compare_field("run_start", want.run_start, got.run_start);
      compare_field("run_length", want.run_length, got.run_length);
      compare_field("pixel_value", want.pixel_value, got.pixel_value);
      compare_field("line_first", want.line_first, got.line_first);
      compare_field("line_copies", want.line_copies, got.line_copies);
      compare_field("page_complete", want.page_complete, got.page_complete);
      compare_field("last", want.last, got.last);
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rpld_pkg::*;
  import rpld_tb_pkg::*;

  localparam int CLK_HALF         = 6;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 500;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rpld_in_if  in_if ();
  rpld_out_if out_if ();
  rpld_cfg_if cfg_if ();

  raster_packbits_line_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  line_decode_scoreboard decoder_sb;
  int unsigned           burst_left  = 0;
  int unsigned           cycle_count = 0;
  bit                    hold_request = 0;
  logic [7:0]            directed_stream[$];

  always #(CLK_HALF) clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Check every word taken from the result port
  always @(posedge clk_i) begin : result_monitor
    result_t seen;
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen.out_kind      = out_if.out_kind;
      seen.run_start     = out_if.run_start;
      seen.run_length    = out_if.run_length;
      seen.pixel_value   = out_if.pixel_value;
      seen.line_first    = out_if.line_first;
      seen.line_copies   = out_if.line_copies;
      seen.page_complete = out_if.page_complete;
      seen.last          = out_if.last;
      decoder_sb.check_word(seen);
    end
  end

  // Stall the result port in segments of varying density, once for a long stretch
  initial begin : result_sink
    int unsigned mode;
    int unsigned seg;
    out_if.ready = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 0;
        repeat (LONG_HOLD_CYCLES) begin
          @(negedge clk_i);
          out_if.ready <= 1'b0;
        end
      end else begin
        mode = $urandom_range(0, 3);
        seg = $urandom_range(10, 120);
        repeat (seg) begin
          @(negedge clk_i);
          case (mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= 1'($urandom_range(0, 1));
            2:       out_if.ready <= ($urandom_range(0, 3) == 0);
            default: out_if.ready <= ~out_if.ready;
          endcase
        end
      end
    end
  end

  // Offer one byte in bursts with random gaps; hold until taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_if.valid <= 1'b1;
    in_if.stream_byte <= b;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    decoder_sb.decode_byte(b);
    burst_left--;
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (decoder_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    decoder_sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Upper data bits of the pixel-size write are junk the block must drop
  task automatic configure(input logic [BPP_W-1:0] bpp,
                           input logic [COORD_BITS-1:0] width,
                           input logic [COORD_BITS-1:0] height);
    write_reg(REG_BPP, {14'($urandom), bpp});
    write_reg(REG_WIDTH, width);
    write_reg(REG_HEIGHT, height);
  endtask

  // Mostly well-formed codes for the decoder's current phase, some noise
  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    int unsigned white_cut;
    int unsigned run_cut;
    roll = $urandom_range(0, 99);
    white_cut = (decoder_sb.eff_width() > 256) ? 60 : 14;
    run_cut = (decoder_sb.eff_width() > 256) ? 85 : 57;
    if (roll < 4) return 8'($urandom);
    case (decoder_sb.phase)
      DEC_REPEAT: begin
        if (roll < 10) return 8'hFF;
        if (roll < 20) return 8'($urandom);
        return 8'($urandom_range(0, 3));
      end
      DEC_CODE: begin
        if (roll < white_cut) return CODE_WHITE;
        if (roll < run_cut) begin
          return (roll < 25) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 7));
        end
        if (roll < 92) return 8'(257 - $urandom_range(2, 8));
        return 8'($urandom_range(129, 255));
      end
      default: return 8'($urandom);
    endcase
  endfunction

  // Stream items; re-arm with a height write whenever the page fills up
  task automatic run_stream(input int unsigned count);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      if (decoder_sb.page_done) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        go_idle();
        wait_drained();
        write_reg(REG_HEIGHT, decoder_sb.height_reg);
      end else begin
        send_byte(pick_byte());
        sent++;
      end
    end
    go_idle();
    wait_drained();
  endtask

  initial begin
    decoder_sb = new();
    in_if.valid = 1'b0;
    in_if.stream_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset defaults: one white line fills the one-line page, then a flagged byte.
    // Then full pixels: clipped run, literal overrunning the line whose leftover
    // bytes become the next line, clamped copy count, bytes after page end.
    directed_stream = '{8'h00, CODE_WHITE, 8'hFF,
                        8'h00, CODE_RUN_MAX, 8'h12, 8'h34, 8'h56,
                        8'h01, CODE_LIT_MAX, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                        8'h80, 8'h7F, 8'h01, 8'hA5, 8'h5A, 8'hC3,
                        8'hFF, CODE_WHITE, 8'h00, 8'hFF};
    foreach (directed_stream[i]) begin
      if (i == 3) begin
        go_idle();
        wait_drained();
        configure(2'd3, 16'd4, 16'd4);
      end
      send_byte(directed_stream[i]);
    end
    go_idle();
    wait_drained();

    // Gray, with a write to the empty index mid-stream that must not re-arm
    configure(2'd1, 16'd16, 16'd40);
    run_stream(150);
    write_reg(REG_UNUSED, 16'($urandom));
    run_stream(150);

    // Long result stall while bytes keep coming
    configure(2'd2, 16'd5, 16'd20);
    hold_request = 1;
    run_stream(250);

    // All-zero registers act as one
    configure(2'd0, 16'd0, 16'd0);
    run_stream(20);

    configure(2'd3, 16'hFFFF, 16'd3);
    run_stream(250);

    configure(2'd3, 16'd7, 16'hFFFF);
    run_stream(400);

    configure(2'd1, 16'd1, 16'hFFFF);
    run_stream(150);

    configure(2'd2, 16'd12, 16'd10);
    run_stream(250);

    configure(2'd3, 16'd3, 16'd6);
    run_stream(200);

    if (decoder_sb.failures == 0 && decoder_sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/rpld_pkg.sv
sv/rpld_in_if.sv
sv/rpld_out_if.sv
sv/rpld_cfg_if.sv
sv/raster_packbits_line_decoder.sv
sv/rpld_checker.sv
sim/rpld_tb_pkg.sv
sim/tb_top.sv
